>>> rtl/bfas_pkg.sv
`timescale 1ns / 1ps

package bfas_pkg;

  localparam int COL_W       = 8;
  localparam int ROW_W       = 6;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 32;
  localparam int COL_COUNT   = 256;
  localparam int ROW_COUNT   = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_ALIGN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_ALIGN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_FRACTION = 3'd6;

  localparam logic [1:0] ALIGN_CENTER = 2'd1;
  localparam logic [1:0] ALIGN_END    = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [8:0] ox;
    logic [6:0] oy;
    logic [8:0] out_w;
    logic [6:0] out_h;
  } geom_t;

  typedef struct packed {
    logic             is_query;
    logic             covered;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] rgba;
  } item_t;

endpackage

>>> rtl/bfas_div.sv
`timescale 1ns / 1ps

module bfas_div import bfas_pkg::*; #(
  parameter int NW = 16,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign shifted = {rem, quo[NW-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo   <= num;
        rem   <= '0;
        den_r <= den;
        cnt   <= '0;
        run   <= 1'b1;
      end else if (run) begin
        quo <= {quo[NW-2:0], ge};
        rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/bfas_setup.sv
`timescale 1ns / 1ps

module bfas_setup import bfas_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 64,
  parameter int FRACTION_BITS     = 8,
  localparam int XW = $clog2(MAX_SOURCE_WIDTH),
  localparam int YW = $clog2(MAX_SOURCE_HEIGHT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  busy,
  output geom_t                 geom,
  output logic                  tab_we_x,
  output logic                  tab_we_y,
  output logic [COL_W-1:0]      tab_idx,
  output logic [XW+FRACTION_BITS:0] tab_x_data,
  output logic [YW+FRACTION_BITS:0] tab_y_data
);

  localparam int F  = FRACTION_BITS;
  localparam int NW = 9 + F;
  localparam int QW = 18 + F;
  localparam int PW = F + 10;
  localparam logic [8:0] MAXW9 = (MAX_SOURCE_WIDTH > 511) ? 9'd511 : 9'(MAX_SOURCE_WIDTH);
  localparam logic [6:0] MAXH7 = (MAX_SOURCE_HEIGHT > 127) ? 7'd127 : 7'(MAX_SOURCE_HEIGHT);
  localparam logic [F:0]    ONE    = {1'b1, {F{1'b0}}};
  localparam logic [QW-1:0] HALF_Q = QW'(1) << (F - 1);
  localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_DIVW  = 11'b00000000010,
    ST_DIVH  = 11'b00000000100,
    ST_SCALE = 11'b00000001000,
    ST_SIZE  = 11'b00000010000,
    ST_PLACE = 11'b00000100000,
    ST_OFFS  = 11'b00001000000,
    ST_DIVX  = 11'b00010000000,
    ST_FILLX = 11'b00100000000,
    ST_DIVY  = 11'b01000000000,
    ST_FILLY = 11'b10000000000
  } setup_state_t;

  setup_state_t state;
  logic         kick;

  logic [8:0] src_w_reg, dst_w_reg, fill_reg;
  logic [6:0] src_h_reg, dst_h_reg;
  logic [1:0] h_align, v_align;

  logic [8:0] sw, dw, fill;
  logic [6:0] sh, dh;

  logic [NW-1:0] div_num, div_quo;
  logic [9:0]    div_den, div_rem;
  logic          div_done;

  logic [F:0]    scale_w, scale_h, smin, scale_sat, t;
  logic [PW-1:0] prod_s, prod_w, prod_h, t_sum, rw_sum, rh_sum;
  logic [9:0]    rw, rh;

  logic [QW-1:0] q, sq, c, top, sx, x0f;
  logic [9:0]    r, sr, dd_r, dd;
  logic [10:0]   r2, rs;
  logic          ge2, gef, flag;
  logic [8:0]    p, lim, s_ax;

  always_comb begin
    sw = src_w_reg;
    if (src_w_reg == 9'd0) sw = 9'd1;
    else if (src_w_reg > MAXW9) sw = MAXW9;
    sh = src_h_reg;
    if (src_h_reg == 7'd0) sh = 7'd1;
    else if (src_h_reg > MAXH7) sh = MAXH7;
    dw   = (dst_w_reg == 9'd0) ? 9'd1 : dst_w_reg;
    dh   = (dst_h_reg == 7'd0) ? 7'd1 : dst_h_reg;
    fill = (fill_reg > 9'd256) ? 9'd256 : fill_reg;
  end

  always_comb begin
    case (state)
      ST_DIVH: begin
        div_num = NW'({dh, {F{1'b0}}});
        div_den = 10'(sh);
      end
      ST_DIVX: begin
        div_num = {sw, {F{1'b0}}};
        div_den = {geom.out_w, 1'b0};
      end
      ST_DIVY: begin
        div_num = NW'({sh, {F{1'b0}}});
        div_den = 10'({geom.out_h, 1'b0});
      end
      default: begin
        div_num = {dw, {F{1'b0}}};
        div_den = 10'(sw);
      end
    endcase
  end

  bfas_div #(.NW(NW), .DW(10)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (kick),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    scale_sat = (div_quo > NW'(ONE)) ? ONE : div_quo[F:0];
    smin      = (scale_w < scale_h) ? scale_w : scale_h;
    t_sum     = prod_s + PW'(128);
    t         = t_sum[F+8:8];
    rw_sum    = prod_w + HALF_P;
    rh_sum    = prod_h + HALF_P;
    rw        = rw_sum[F+9:F];
    rh        = rh_sum[F+9:F];
    dd        = (state == ST_DIVY) ? 10'({geom.out_h, 1'b0}) : {geom.out_w, 1'b0};
    r2        = {div_rem, 1'b0};
    ge2       = r2 >= {1'b0, dd};
    rs        = 11'(r) + 11'(sr);
    gef       = rs >= 11'(dd_r);
    s_ax      = (state == ST_FILLY) ? 9'(sh) : sw;
    c         = (q < HALF_Q) ? '0 : q - HALF_Q;
    top       = (QW'(s_ax) - QW'(1)) << F;
    sx        = (c > top) ? top : c;
    x0f       = sx >> F;
    flag      = (x0f + QW'(1)) >= QW'(s_ax);
    if (state == ST_FILLY) lim = (geom.out_h > 7'd64) ? 9'd64 : 9'(geom.out_h);
    else lim = (geom.out_w > 9'd256) ? 9'd256 : geom.out_w;
  end

  assign busy       = state != ST_IDLE;
  assign tab_we_x   = state == ST_FILLX;
  assign tab_we_y   = state == ST_FILLY;
  assign tab_idx    = p[COL_W-1:0];
  assign tab_x_data = {flag, (XW+F)'(sx)};
  assign tab_y_data = {flag, (YW+F)'(sx)};

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_reg <= 9'd256;
      src_h_reg <= 7'd64;
      dst_w_reg <= 9'd256;
      dst_h_reg <= 7'd64;
      h_align   <= 2'd0;
      v_align   <= 2'd0;
      fill_reg  <= 9'd256;
      state     <= ST_DIVW;
      kick      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
        REG_SOURCE_HEIGHT: src_h_reg <= cfg_data[6:0];
        REG_DEST_WIDTH:    dst_w_reg <= cfg_data;
        REG_DEST_HEIGHT:   dst_h_reg <= cfg_data[6:0];
        REG_HORIZ_ALIGN:   h_align   <= cfg_data[1:0];
        REG_VERT_ALIGN:    v_align   <= cfg_data[1:0];
        REG_FILL_FRACTION: fill_reg  <= cfg_data;
        default: ;
      endcase
      state <= ST_DIVW;
      kick  <= 1'b1;
    end else begin
      kick <= 1'b0;
      case (state)
        ST_DIVW: begin
          if (div_done && !kick) begin
            scale_w <= scale_sat;
            state   <= ST_DIVH;
            kick    <= 1'b1;
          end
        end
        ST_DIVH: begin
          if (div_done && !kick) begin
            scale_h <= scale_sat;
            state   <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod_s <= PW'(smin) * PW'(fill);
          state  <= ST_SIZE;
        end
        ST_SIZE: begin
          prod_w <= PW'(sw) * PW'(t);
          prod_h <= PW'(sh) * PW'(t);
          state  <= ST_PLACE;
        end
        ST_PLACE: begin
          if (rw == 10'd0) geom.out_w <= 9'd1;
          else if (rw > 10'(dw)) geom.out_w <= dw;
          else geom.out_w <= rw[8:0];
          if (rh == 10'd0) geom.out_h <= 7'd1;
          else if (rh > 10'(dh)) geom.out_h <= dh;
          else geom.out_h <= rh[6:0];
          state <= ST_OFFS;
        end
        ST_OFFS: begin
          case (h_align)
            ALIGN_CENTER: geom.ox <= (dw - geom.out_w) >> 1;
            ALIGN_END:    geom.ox <= dw - geom.out_w;
            default:      geom.ox <= 9'd0;
          endcase
          case (v_align)
            ALIGN_CENTER: geom.oy <= (dh - geom.out_h) >> 1;
            ALIGN_END:    geom.oy <= dh - geom.out_h;
            default:      geom.oy <= 7'd0;
          endcase
          state <= ST_DIVX;
          kick  <= 1'b1;
        end
        ST_DIVX, ST_DIVY: begin
          if (div_done && !kick) begin
            q     <= QW'(div_quo);
            r     <= div_rem;
            sq    <= QW'({div_quo, 1'b0}) + QW'(ge2);
            sr    <= ge2 ? 10'(r2 - {1'b0, dd}) : r2[9:0];
            dd_r  <= dd;
            p     <= 9'd0;
            state <= (state == ST_DIVX) ? ST_FILLX : ST_FILLY;
          end
        end
        ST_FILLX, ST_FILLY: begin
          q <= q + sq + QW'(gef);
          r <= gef ? 10'(rs - 11'(dd_r)) : rs[9:0];
          p <= p + 9'd1;
          if (p == lim - 9'd1) begin
            if (state == ST_FILLX) begin
              state <= ST_DIVY;
              kick  <= 1'b1;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bfas_front.sv
`timescale 1ns / 1ps

module bfas_front import bfas_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              busy,
  input  geom_t             geom,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [COL_W-1:0]  pixel_col,
  input  logic [ROW_W-1:0]  pixel_row,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  input  logic [CHAN_W-1:0] in_alpha,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_pop
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  item_t             item;
  logic              in_range, push;

  always_comb begin
    item.is_query = cmd == CMD_QUERY;
    item.covered  = (10'(pixel_col) >= 10'(geom.ox)) &&
                    (10'(pixel_col) < 10'(geom.ox) + 10'(geom.out_w)) &&
                    (8'(pixel_row) >= 8'(geom.oy)) &&
                    (8'(pixel_row) < 8'(geom.oy) + 8'(geom.out_h));
    item.col      = (cmd == CMD_QUERY) ? pixel_col - geom.ox[COL_W-1:0] : pixel_col;
    item.row      = (cmd == CMD_QUERY) ? pixel_row - geom.oy[ROW_W-1:0] : pixel_row;
    item.rgba     = {in_alpha, in_blue, in_green, in_red};
    in_range      = (32'(pixel_col) < MAX_SOURCE_WIDTH) && (32'(pixel_row) < MAX_SOURCE_HEIGHT);
  end

  assign in_stall = busy || (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && (item.is_query || in_range);
  assign q_valid  = count != '0;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end
  end

endmodule

>>> rtl/bfas_back.sv
`timescale 1ns / 1ps

module bfas_back import bfas_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 64,
  parameter int FRACTION_BITS     = 8,
  localparam int XW = $clog2(MAX_SOURCE_WIDTH),
  localparam int YW = $clog2(MAX_SOURCE_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic              tab_we_x,
  input  logic              tab_we_y,
  input  logic [COL_W-1:0]  tab_idx,
  input  logic [XW+FRACTION_BITS:0] tab_x_data,
  input  logic [YW+FRACTION_BITS:0] tab_y_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_alpha,
  output logic              covered
);

  localparam int F   = FRACTION_BITS;
  localparam int HW  = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int HH  = (MAX_SOURCE_HEIGHT + 1) / 2;
  localparam int BD  = HW * HH;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int WW  = 2 * F + 1;
  localparam int MW  = 2 * F + 9;
  localparam int AW  = 2 * F + 10;
  localparam logic [F:0]    ONE = {1'b1, {F{1'b0}}};
  localparam logic [AW-1:0] RND = AW'(1) << (2 * F - 1);

  logic en;

  logic [XW+F:0] xtab [COL_COUNT];
  logic [YW+F:0] ytab [ROW_COUNT];

  logic [3:0]     bank_we;
  logic [BAW-1:0] wr_addr;
  logic [BAW-1:0] rd_addr [4];
  logic [PIX_W-1:0] bank_rd [4];

  logic          v1, cov1;
  logic [XW+F:0] xt;
  logic [YW+F:0] yt;

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic [XW:0]   xe;
  logic [YW:0]   ye;

  logic         v2, cov2, x0p, x1p, y0p, y1p;
  logic [F-1:0] fx, fy;

  logic          v3, cov3;
  logic [WW-1:0] w [4];
  logic [PIX_W-1:0] tap [4];

  logic          v4, cov4;
  logic [MW-1:0] prod [4][4];
  logic [AW-1:0] acc [4];
  logic [F:0]    omx, omy;

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (tab_we_x) xtab[tab_idx] <= tab_x_data;
    if (tab_we_y) ytab[tab_idx[ROW_W-1:0]] <= tab_y_data;
    if (en) begin
      xt <= xtab[q_item.col];
      yt <= ytab[q_item.row];
    end
  end

  always_comb begin
    bank_we = '0;
    if (q_pop && !q_item.is_query) bank_we[{q_item.row[0], q_item.col[0]}] = 1'b1;
    wr_addr = BAW'(32'(q_item.row[ROW_W-1:1]) * HW + 32'(q_item.col[COL_W-1:1]));
  end

  always_comb begin
    x0 = xt[XW+F-1:F];
    y0 = yt[YW+F-1:F];
    x1 = xt[XW+F] ? x0 : x0 + 1'b1;
    y1 = yt[YW+F] ? y0 : y0 + 1'b1;
    xe = (XW+1)'(x0) + 1'b1;
    ye = (YW+1)'(y0) + 1'b1;
    rd_addr[0] = BAW'(32'(ye[YW:1]) * HW + 32'(xe[XW:1]));
    rd_addr[1] = BAW'(32'(ye[YW:1]) * HW + 32'(x0[XW-1:1]));
    rd_addr[2] = BAW'(32'(y0[YW-1:1]) * HW + 32'(xe[XW:1]));
    rd_addr[3] = BAW'(32'(y0[YW-1:1]) * HW + 32'(x0[XW-1:1]));
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BD];
    always_ff @(posedge clk) begin
      if (bank_we[b]) mem[wr_addr] <= q_item.rgba;
      if (en) bank_rd[b] <= mem[rd_addr[b]];
    end
  end

  always_comb begin
    omx = ONE - (F+1)'(fx);
    omy = ONE - (F+1)'(fy);
    for (int k = 0; k < 4; k++) begin
      acc[k] = AW'(prod[k][0]) + AW'(prod[k][1]) + AW'(prod[k][2]) + AW'(prod[k][3]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov1 <= q_item.covered;
      cov2 <= cov1;
      fx   <= xt[F-1:0];
      fy   <= yt[F-1:0];
      x0p  <= x0[0];
      x1p  <= x1[0];
      y0p  <= y0[0];
      y1p  <= y1[0];
      cov3 <= cov2;
      w[0] <= WW'(omx) * WW'(omy);
      w[1] <= WW'(fx) * WW'(omy);
      w[2] <= WW'(omx) * WW'(fy);
      w[3] <= WW'(fx) * WW'(fy);
      tap[0] <= bank_rd[{y0p, x0p}];
      tap[1] <= bank_rd[{y0p, x1p}];
      tap[2] <= bank_rd[{y1p, x0p}];
      tap[3] <= bank_rd[{y1p, x1p}];
      cov4 <= cov3;
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod[k][j] <= MW'(tap[j][8*k +: 8]) * MW'(w[j]);
        end
      end
      covered   <= cov4;
      out_red   <= cov4 ? acc[0][2*F+7:2*F] : '0;
      out_green <= cov4 ? acc[1][2*F+7:2*F] : '0;
      out_blue  <= cov4 ? acc[2][2*F+7:2*F] : '0;
      out_alpha <= cov4 ? acc[3][2*F+7:2*F] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= q_pop && q_item.is_query;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

>>> rtl/bilinear_fit_align_scaler_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Word
// in       input      in_valid / in_stall       cmd, pixel_col, pixel_row, in_red..in_alpha
// out      output     out_valid / out_stall     out_red..out_alpha, covered
// cfg      input      cfg_valid / cfg_ready     cfg_index, cfg_data
// One word per clock in both directions while in_stall and out_stall stay low.
// Loads give no result word.
// After reset and after every cfg write, in_stall holds high while the geometry and
// coordinate tables are rebuilt by four serial divides and a table walk over
// min(out width,256) column and min(out height,64) row entries.
// out_stall freezes the back pipeline; the 4-word queue keeps taking input until full.

module bilinear_fit_align_scaler_top import bfas_pkg::*; #(
  parameter int MAX_SOURCE_WIDTH  = 256,
  parameter int MAX_SOURCE_HEIGHT = 64,
  parameter int FRACTION_BITS     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [COL_W-1:0]      pixel_col,
  input  logic [ROW_W-1:0]      pixel_row,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  input  logic [CHAN_W-1:0]     in_alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  output logic [CHAN_W-1:0]     out_alpha,
  output logic                  covered,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW = $clog2(MAX_SOURCE_HEIGHT);

  logic             busy;
  geom_t            geom;
  logic             tab_we_x, tab_we_y;
  logic [COL_W-1:0] tab_idx;
  logic [XW+FRACTION_BITS:0] tab_x_data;
  logic [YW+FRACTION_BITS:0] tab_y_data;
  logic             q_valid, q_pop;
  item_t            q_item;

  assign cfg_ready = 1'b1;

  bfas_setup #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_setup (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .geom       (geom),
    .tab_we_x   (tab_we_x),
    .tab_we_y   (tab_we_y),
    .tab_idx    (tab_idx),
    .tab_x_data (tab_x_data),
    .tab_y_data (tab_y_data)
  );

  bfas_front #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .busy      (busy),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_alpha  (in_alpha),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  bfas_back #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .tab_we_x   (tab_we_x),
    .tab_we_y   (tab_we_y),
    .tab_idx    (tab_idx),
    .tab_x_data (tab_x_data),
    .tab_y_data (tab_y_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .covered    (covered)
  );

endmodule

>>> rtl/bfas_checker.sv
`timescale 1ns / 1ps

module bfas_checker import bfas_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue,
  input logic [CHAN_W-1:0] out_alpha,
  input logic              covered,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(covered))
    else $error("stalled result word changed");

  a_uncovered_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !covered |-> out_red == '0 && out_green == '0 &&
      out_blue == '0 && out_alpha == '0)
    else $error("uncovered pixel not zero");

  a_reset_stall: assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input open or result valid right after reset");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input open during table rebuild");

endmodule

bind bilinear_fit_align_scaler_top bfas_checker u_checker (.*);
